// ----- rtl/drsr_pkg.sv -----
// Shared constants, types and helpers for the disc and ring span rasterizer.
package drsr_pkg;

    // Panel and band limits
    localparam int PANEL_WIDTH = 320;
    localparam int BAND_ROWS   = 16;
    localparam int CLIP_BOUND  = 16384;

    // Square-root unit: top bit of the bit-by-bit root and its step count
    localparam int ROOT_TOP    = 1 << 14;
    localparam int ROOT_STEPS  = 8;
    localparam int ROOT_W      = 16;
    localparam int ROOT_BIT_W  = 15;
    localparam int ROOT_CNT_W  = $clog2(ROOT_STEPS);
    localparam int HALF_W      = 8;

    // Command queue between front and back
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    // Field widths
    localparam int CRD_W       = 16;
    localparam int COORD_W     = 18;
    localparam int LEN_W       = 9;
    localparam int BH_W        = 5;
    localparam int RAD_W       = 7;
    localparam int COLOR_W     = 16;
    localparam int REG_IDX_W   = 3;
    localparam int SQ_W        = 2 * RAD_W;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_BAND_LEFT   = 3'd0,
        REG_BAND_TOP    = 3'd1,
        REG_BAND_WIDTH  = 3'd2,
        REG_BAND_HEIGHT = 3'd3,
        REG_CLIP_LEFT   = 3'd4,
        REG_CLIP_TOP    = 3'd5,
        REG_CLIP_RIGHT  = 3'd6,
        REG_CLIP_BOTTOM = 3'd7
    } t_reg_idx;

    // Classified command handed from front to back
    typedef struct packed {
        logic                     ring;
        logic signed [CRD_W-1:0]  cx;
        logic signed [CRD_W-1:0]  cy;
        logic [RAD_W-1:0]         ro;
        logic [RAD_W-1:0]         ri;
        logic [COLOR_W-1:0]       color;
        t_coord                   y0;
        t_coord                   y1;
        t_coord                   xl;
        t_coord                   xr;
    } t_job;

    // One output span
    typedef struct packed {
        logic signed [CRD_W-1:0]  row;
        logic signed [CRD_W-1:0]  start;
        logic [LEN_W-1:0]         length;
        logic [COLOR_W-1:0]       color;
        logic                     last;
    } t_span;

    // Status of the square-root unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [HALF_W-1:0] half;
    } t_root_stat;

    function automatic t_coord smax(input t_coord a, input t_coord b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_coord smin(input t_coord a, input t_coord b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ----- rtl/drsr_ifs.sv -----
// Channel interfaces: command input, span output and configuration writes.
interface drsr_cmd_if import drsr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic signed [CRD_W-1:0] centre_x;
    logic signed [CRD_W-1:0] centre_y;
    logic [RAD_W-1:0]        outer_radius;
    logic [RAD_W-1:0]        inner_radius;
    logic [COLOR_W-1:0]      fill_color;

    modport source (output valid, cmd, centre_x, centre_y, outer_radius, inner_radius,
                    fill_color, input ready);
    modport sink   (input valid, cmd, centre_x, centre_y, outer_radius, inner_radius,
                    fill_color, output ready);
endinterface

interface drsr_span_if import drsr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [CRD_W-1:0] span_row;
    logic signed [CRD_W-1:0] span_start;
    logic [LEN_W-1:0]        span_length;
    logic [COLOR_W-1:0]      span_color;
    logic                    last_span;

    modport source (output valid, span_row, span_start, span_length, span_color, last_span,
                    input ready);
    modport sink   (input valid, span_row, span_start, span_length, span_color, last_span,
                    output ready);
endinterface

interface drsr_cfg_if import drsr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [CRD_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/disc_ring_span_rasterizer.sv -----
// Top level of the disc and ring span rasterizer.
// Usage:
//   i_cmd  : one transaction per disc or ring command (centre, radii, colour).
//   o_span : clipped, non-empty spans of the current band, top row first, left
//            span first; last_span marks the final span of a command. A command
//            that covers nothing gives no transaction at all.
//   i_cfg  : band window and clip rectangle registers, written by index; ready
//            is always high. Write only while the block is idle.
// Per row: each covered row takes one root from the shared 8-step square-root
//   unit, or two on a ring row that crosses the hole, and then one span step
//   per side span. Every span is held until the next one, or the end of the
//   command, shows whether it is the last.
//   A two-entry queue lets the front take new commands while the engine works.
// Reset: synchronous, active low; registers return to an open clip rectangle
//   and a 320 by 16 band at the origin, queue and engine empty.
// Stall: when o_span.ready is low the span engine holds, the queue fills and
//   i_cmd.ready drops; nothing is lost or repeated.
module disc_ring_span_rasterizer import drsr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drsr_cmd_if.sink    i_cmd,
    drsr_cfg_if.sink    i_cfg,
    drsr_span_if.source o_span
);

    logic front_valid, front_ready, back_valid, back_ready;
    t_job front_job, back_job;

    drsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg       (i_cfg),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (front_ready)
    );

    drsr_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_data  (front_job),
        .o_push_ready (front_ready),
        .o_pop_valid  (back_valid),
        .o_pop_data   (back_job),
        .i_pop_ready  (back_ready)
    );

    drsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (back_valid),
        .i_job       (back_job),
        .o_job_ready (back_ready),
        .o_span      (o_span)
    );

endmodule

// ----- rtl/drsr_front.sv -----
// Front end: configuration registers, command intake and row/column window setup.
module drsr_front import drsr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drsr_cmd_if.sink   i_cmd,
    drsr_cfg_if.sink   i_cfg,
    output logic       o_job_valid,
    output t_job       o_job,
    input  logic       i_job_ready
);

    logic signed [CRD_W-1:0] r_band_left, r_band_top;
    logic [LEN_W-1:0]        r_band_width;
    logic [BH_W-1:0]         r_band_height;
    logic signed [CRD_W-1:0] r_clip_left, r_clip_top, r_clip_right, r_clip_bottom;

    t_job   r_job;
    logic   r_job_valid;

    logic [LEN_W-1:0] bw;
    logic [BH_W-1:0]  bh;
    t_coord           cy, ro, y_lo, y_hi, x_lo, x_hi;
    logic             keep, accept, push;
    t_job             job_in;

    // Configuration writes, always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_left   <= '0;
            r_band_top    <= '0;
            r_band_width  <= LEN_W'(PANEL_WIDTH);
            r_band_height <= BH_W'(BAND_ROWS);
            r_clip_left   <= CRD_W'(-CLIP_BOUND);
            r_clip_top    <= CRD_W'(-CLIP_BOUND);
            r_clip_right  <= CRD_W'(CLIP_BOUND);
            r_clip_bottom <= CRD_W'(CLIP_BOUND);
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_BAND_LEFT:   r_band_left   <= i_cfg.data;
                REG_BAND_TOP:    r_band_top    <= i_cfg.data;
                REG_BAND_WIDTH:  r_band_width  <= i_cfg.data[LEN_W-1:0];
                REG_BAND_HEIGHT: r_band_height <= i_cfg.data[BH_W-1:0];
                REG_CLIP_LEFT:   r_clip_left   <= i_cfg.data;
                REG_CLIP_TOP:    r_clip_top    <= i_cfg.data;
                REG_CLIP_RIGHT:  r_clip_right  <= i_cfg.data;
                REG_CLIP_BOTTOM: r_clip_bottom <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Row range and column window of the command
    always_comb begin
        bw = (int'(r_band_width) > PANEL_WIDTH) ? LEN_W'(PANEL_WIDTH) : r_band_width;
        bh = (int'(r_band_height) > BAND_ROWS) ? BH_W'(BAND_ROWS) : r_band_height;
        cy = t_coord'(i_cmd.centre_y);
        ro = t_coord'({{(COORD_W-RAD_W){1'b0}}, i_cmd.outer_radius});
        y_lo = smax(smax(t_coord'(cy - ro), t_coord'(r_band_top)), t_coord'(r_clip_top));
        y_hi = smin(smin(t_coord'(cy + ro + t_coord'(1)),
                         t_coord'(t_coord'(r_band_top) +
                                  t_coord'({{(COORD_W-BH_W){1'b0}}, bh}))),
                    t_coord'(r_clip_bottom));
        x_lo = smax(t_coord'(r_band_left), t_coord'(r_clip_left));
        x_hi = smin(t_coord'(t_coord'(r_band_left) +
                             t_coord'({{(COORD_W-LEN_W){1'b0}}, bw})),
                    t_coord'(r_clip_right));
        keep = (y_hi > y_lo) && (x_hi > x_lo);

        job_in.ring  = i_cmd.cmd;
        job_in.cx    = i_cmd.centre_x;
        job_in.cy    = i_cmd.centre_y;
        job_in.ro    = i_cmd.outer_radius;
        job_in.ri    = i_cmd.inner_radius;
        job_in.color = i_cmd.fill_color;
        job_in.y0    = y_lo;
        job_in.y1    = y_hi;
        job_in.xl    = x_lo;
        job_in.xr    = x_hi;
    end

    // Staging register; commands that cover nothing are dropped here
    assign push        = r_job_valid && i_job_ready;
    assign i_cmd.ready = !r_job_valid || i_job_ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else begin
            if (push)
                r_job_valid <= 1'b0;
            if (accept && keep)
                r_job_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep)
            r_job <= job_in;
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

endmodule

// ----- rtl/drsr_fifo.sv -----
// Short command queue between the front end and the span engine.
module drsr_fifo import drsr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push_data,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_job o_pop_data,
    input  logic i_pop_ready
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              push, pop;

    assign o_push_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push)
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(r_wr + 1'b1);
            if (pop)
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(r_rd + 1'b1);
            if (push && !pop)
                r_count <= QCNT_W'(r_count + 1'b1);
            else if (pop && !push)
                r_count <= QCNT_W'(r_count - 1'b1);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push)
            r_mem[r_wr] <= i_push_data;
    end

endmodule

// ----- rtl/drsr_root.sv -----
// Bit-by-bit integer square root, two bits of radicand per cycle, rounded half output.
module drsr_root import drsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ROOT_W-1:0] i_value,
    output t_root_stat        o_stat
);

    logic [ROOT_W-1:0]     r_v, r_r;
    logic [ROOT_BIT_W-1:0] r_bit;
    logic [ROOT_CNT_W-1:0] r_cnt;
    logic                  r_busy, r_done;

    logic [ROOT_W:0]       trial;
    logic                  take;

    assign trial = {1'b0, r_r} + {2'b0, r_bit};
    assign take  = ({1'b0, r_v} >= trial);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= ROOT_CNT_W'(r_cnt + 1'b1);
                if (r_cnt == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One root step per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= ROOT_BIT_W'(ROOT_TOP);
        end else if (r_busy) begin
            if (take) begin
                r_v <= ROOT_W'(r_v - trial[ROOT_W-1:0]);
                r_r <= ROOT_W'((r_r >> 1) + {1'b0, r_bit});
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.half = HALF_W'(({1'b0, r_r} + 1'b1) >> 1);

endmodule

// ----- rtl/drsr_back.sv -----
// Span engine: walks the rows of a command, takes chord roots, clips and emits spans.
module drsr_back import drsr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_job_ready,
    drsr_span_if.source o_span
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SQ    = 5'b00010,
        S_ROOT  = 5'b00100,
        S_SPAN  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state            r_state;
    t_job              r_job;
    t_coord            r_yy;
    logic              r_inner, r_ring_row, r_side;
    logic [HALF_W-1:0] r_ho, r_hi;
    t_span             r_pend, r_out;
    logic              r_pend_valid, r_out_valid;

    t_root_stat        root_stat;
    logic              root_start;
    logic [ROOT_W-1:0] root_value;

    t_coord            dy, cx, hoe, hie, sx, ex, x0, x1;
    logic [RAD_W-1:0]  ady, rad;
    logic [SQ_W-1:0]   sq_diff;
    logic              hit, out_free, can_go, row_done, more_rows;
    t_span             span_new;
    logic              n_out_load;
    t_span             n_out;

    // Row offset and squares for the chord
    always_comb begin
        dy         = t_coord'(r_yy - t_coord'(r_job.cy));
        ady        = dy[COORD_W-1] ? RAD_W'(-dy) : RAD_W'(dy);
        rad        = r_inner ? r_job.ri : r_job.ro;
        sq_diff    = SQ_W'(rad * rad) - SQ_W'(ady * ady);
        root_value = {sq_diff, 2'b00};
        root_start = (r_state == S_SQ);
    end

    drsr_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (root_value),
        .o_stat  (root_stat)
    );

    // Span edges and clipping
    always_comb begin
        cx  = t_coord'(r_job.cx);
        hoe = t_coord'({{(COORD_W-HALF_W){1'b0}}, r_ho});
        hie = t_coord'({{(COORD_W-HALF_W){1'b0}}, r_hi});
        sx  = r_side ? t_coord'(cx + hie + t_coord'(1)) : t_coord'(cx - hoe);
        ex  = (r_side || !r_ring_row) ? t_coord'(cx + hoe + t_coord'(1))
                                      : t_coord'(cx - hie);
        x0  = smax(sx, r_job.xl);
        x1  = smin(ex, r_job.xr);
        hit = (x1 > x0);

        span_new.row    = r_yy[CRD_W-1:0];
        span_new.start  = x0[CRD_W-1:0];
        span_new.length = LEN_W'(x1 - x0);
        span_new.color  = r_job.color;
        span_new.last   = 1'b0;

        out_free  = !r_out_valid || o_span.ready;
        can_go    = !hit || !r_pend_valid || out_free;
        row_done  = r_side || !r_ring_row;
        more_rows = (t_coord'(r_yy + t_coord'(1)) < r_job.y1);
    end

    // Output register load: pending span moves out when a newer one arrives or at the end
    always_comb begin
        n_out_load = 1'b0;
        n_out      = r_pend;
        if (r_state == S_SPAN && hit && r_pend_valid && out_free) begin
            n_out_load = 1'b1;
        end else if (r_state == S_FLUSH && r_pend_valid && out_free) begin
            n_out_load = 1'b1;
            n_out.last = 1'b1;
        end
    end

    assign o_job_ready = (r_state == S_IDLE);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_inner      <= 1'b0;
            r_side       <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_inner <= 1'b0;
                        r_side  <= 1'b0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (root_stat.done) begin
                        if (!r_inner) begin
                            if (r_job.ring && ady <= r_job.ri) begin
                                r_inner <= 1'b1;
                                r_state <= S_SQ;
                            end else begin
                                r_state <= S_SPAN;
                            end
                        end else begin
                            r_state <= S_SPAN;
                        end
                    end
                end
                S_SPAN: begin
                    if (can_go) begin
                        if (hit)
                            r_pend_valid <= 1'b1;
                        if (row_done) begin
                            r_side  <= 1'b0;
                            r_inner <= 1'b0;
                            r_state <= more_rows ? S_SQ : S_FLUSH;
                        end else begin
                            r_side <= 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid) begin
            r_job <= i_job;
            r_yy  <= i_job.y0;
        end
        if (r_state == S_ROOT && root_stat.done) begin
            if (!r_inner) begin
                r_ho       <= root_stat.half;
                r_ring_row <= r_job.ring && (ady <= r_job.ri);
            end else begin
                r_hi <= root_stat.half;
            end
        end
        if (r_state == S_SPAN && can_go) begin
            if (hit)
                r_pend <= span_new;
            if (row_done && more_rows)
                r_yy <= t_coord'(r_yy + t_coord'(1));
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_span.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load)
            r_out <= n_out;
    end

    assign o_span.valid       = r_out_valid;
    assign o_span.span_row    = r_out.row;
    assign o_span.span_start  = r_out.start;
    assign o_span.span_length = r_out.length;
    assign o_span.span_color  = r_out.color;
    assign o_span.last_span   = r_out.last;

    // Checks
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending span left over between commands");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> (r_yy >= r_job.y0 && r_yy < r_job.y1))
        else $error("row walked outside its window");

    a_root_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_start |-> !root_stat.busy)
        else $error("root unit restarted while busy");

    a_root_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_stat.done |-> (r_state == S_ROOT))
        else $error("root result arrived with nobody waiting");

    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.length != '0))
        else $error("empty span presented");

endmodule

// ----- dv/tb_disc_ring_span_rasterizer.sv -----
// Self-checking testbench for the disc and ring span rasterizer.
module tb_disc_ring_span_rasterizer;
    import drsr_pkg::*;

    // Shape kind codes carried on the command channel
    localparam logic SHAPE_DISC = 1'b0;
    localparam logic SHAPE_RING = 1'b1;

    localparam int SETTLE_CYCLES = 2000;   // four full ring commands in flight, with margin
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RUN_LIMIT     = 3000000;
    localparam int PRINT_CAP     = 200;

    typedef struct packed {
        logic                    kind;
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic [RAD_W-1:0]        ro;
        logic [RAD_W-1:0]        ri;
        logic [COLOR_W-1:0]      color;
    } t_shape_cmd;

    logic i_clk;
    logic i_rst_n;

    drsr_cmd_if  cmd_ch ();
    drsr_cfg_if  cfg_ch ();
    drsr_span_if span_ch ();

    disc_ring_span_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_span  (span_ch)
    );

    // Local copy of the band window and clip rectangle
    int reg_band_left   = 0;
    int reg_band_top    = 0;
    int reg_band_width  = PANEL_WIDTH;
    int reg_band_height = BAND_ROWS;
    int reg_clip_left   = -CLIP_BOUND;
    int reg_clip_top    = -CLIP_BOUND;
    int reg_clip_right  = CLIP_BOUND;
    int reg_clip_bottom = CLIP_BOUND;

    t_shape_cmd pending_cmds[$];
    t_shape_cmd cmd_on_bus;
    t_span      span_expect[$];
    t_span      want_span;
    int         n_errors = 0;
    int         span_count = 0;
    int         src_idle_pct = 11;
    int         sink_idle_pct = 47;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int imin(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // Bit-by-bit integer square root, top bit 2^14
    function automatic int unsigned bit_root(input int unsigned v);
        int unsigned r;
        int unsigned b;
        r = 0;
        b = ROOT_TOP;
        if (v == 0) return 0;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Half chord rounded to the nearest pixel, root taken at double scale
    function automatic int chord_reach(input int r, input int dy);
        int v;
        v = r * r - dy * dy;
        if (v <= 0) return 0;
        return int'((bit_root(4 * v) + 1) / 2);
    endfunction

    // Clip one span to band and clip rectangle; queue it if anything is left
    function automatic int emit_span(input int row, input int x, input int w,
                                     input logic [COLOR_W-1:0] color);
        int    x0;
        int    x1;
        t_span s;
        x0 = imax(imax(x, reg_band_left), reg_clip_left);
        x1 = imin(imin(x + w, reg_band_left + imin(reg_band_width, PANEL_WIDTH)),
                  reg_clip_right);
        if (x1 <= x0) return 0;
        s.row    = row[CRD_W-1:0];
        s.start  = x0[CRD_W-1:0];
        s.length = LEN_W'(x1 - x0);
        s.color  = color;
        s.last   = 1'b0;
        span_expect.push_back(s);
        return 1;
    endfunction

    // Expected spans of one command, top row first, left span first
    function automatic void predict_spans(input t_shape_cmd c);
        int cx;
        int cy;
        int ro;
        int ri;
        int y0;
        int y1;
        int yy;
        int dy;
        int outer;
        int hole;
        int n;
        cx = c.cx;
        cy = c.cy;
        ro = c.ro;
        ri = c.ri;
        n  = 0;
        y0 = imax(imax(cy - ro, reg_band_top), reg_clip_top);
        y1 = imin(imin(cy + ro + 1, reg_band_top + imin(reg_band_height, BAND_ROWS)),
                  reg_clip_bottom);
        for (yy = y0; yy < y1; yy++) begin
            dy    = yy - cy;
            outer = chord_reach(ro, dy);
            if (c.kind == SHAPE_DISC || dy > ri || dy < -ri) begin
                n += emit_span(yy, cx - outer, 2 * outer + 1, c.color);
            end else begin
                // row crosses the hole: left and right pieces
                hole = chord_reach(ri, dy);
                n += emit_span(yy, cx - outer, outer - hole, c.color);
                n += emit_span(yy, cx + hole + 1, outer - hole, c.color);
            end
        end
        if (n > 0) span_expect[span_expect.size() - 1].last = 1'b1;
    endfunction

    function automatic void apply_reg(input t_reg_idx idx, input logic [CRD_W-1:0] data);
        case (idx)
            REG_BAND_LEFT:   reg_band_left   = $signed(data);
            REG_BAND_TOP:    reg_band_top    = $signed(data);
            REG_BAND_WIDTH:  reg_band_width  = int'(data[LEN_W-1:0]);
            REG_BAND_HEIGHT: reg_band_height = int'(data[BH_W-1:0]);
            REG_CLIP_LEFT:   reg_clip_left   = $signed(data);
            REG_CLIP_TOP:    reg_clip_top    = $signed(data);
            REG_CLIP_RIGHT:  reg_clip_right  = $signed(data);
            REG_CLIP_BOTTOM: reg_clip_bottom = $signed(data);
            default: ;
        endcase
    endfunction

    // Mostly shapes aimed at the current band, some anywhere in the plane
    function automatic t_shape_cmd make_random_cmd();
        t_shape_cmd c;
        int         bw;
        int         bh;
        int         ro;
        int         ri;
        int         cx;
        int         cy;
        bw = imin(reg_band_width, PANEL_WIDTH);
        bh = imin(reg_band_height, BAND_ROWS);
        c.kind  = ($urandom_range(0, 1) != 0) ? SHAPE_RING : SHAPE_DISC;
        c.color = COLOR_W'($urandom);
        ro = ($urandom_range(0, 99) < 50) ? $urandom_range(0, 24) : $urandom_range(0, 127);
        ri = ($urandom_range(0, 99) < 70) ? $urandom_range(0, ro) : $urandom_range(0, 127);
        if ($urandom_range(0, 99) < 85) begin
            cy = reg_band_top - ro + int'($urandom_range(0, bh + 2 * ro));
            cx = reg_band_left - ro + int'($urandom_range(0, bw + 2 * ro));
        end else begin
            cx = $urandom;
            cy = $urandom;
        end
        c.cx = cx[CRD_W-1:0];
        c.cy = cy[CRD_W-1:0];
        c.ro = ro[RAD_W-1:0];
        c.ri = ri[RAD_W-1:0];
        return c;
    endfunction

    task automatic add_cmd(input logic kind, input int cx, input int cy, input int ro,
                           input int ri, input int color);
        t_shape_cmd c;
        c.kind  = kind;
        c.cx    = cx[CRD_W-1:0];
        c.cy    = cy[CRD_W-1:0];
        c.ro    = ro[RAD_W-1:0];
        c.ri    = ri[RAD_W-1:0];
        c.color = color[COLOR_W-1:0];
        pending_cmds.push_back(c);
    endtask

    task automatic add_random(input int count);
        repeat (count) pending_cmds.push_back(make_random_cmd());
    endtask

    task automatic report_mismatch(input string msg);
        if (n_errors < PRINT_CAP) $display("ERROR: %s", msg);
        n_errors++;
    endtask

    // Register write transaction; only issued while the block is idle
    task automatic write_reg(input t_reg_idx idx, input int value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value[CRD_W-1:0];
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        apply_reg(idx, cfg_ch.data);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_all_regs(input int bl, input int bt, input int bw, input int bh,
                                  input int cl, input int ct, input int cr, input int cb);
        write_reg(REG_BAND_LEFT, bl);
        write_reg(REG_BAND_TOP, bt);
        write_reg(REG_BAND_WIDTH, bw);
        write_reg(REG_BAND_HEIGHT, bh);
        write_reg(REG_CLIP_LEFT, cl);
        write_reg(REG_CLIP_TOP, ct);
        write_reg(REG_CLIP_RIGHT, cr);
        write_reg(REG_CLIP_BOTTOM, cb);
    endtask

    // Hold off until every queued command is taken and every span is back,
    // then let commands that draw nothing finish inside the block
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        do begin
            @(posedge i_clk);
            if (pending_cmds.size() == 0 && !cmd_ch.valid) quiet++;
        end while ((pending_cmds.size() != 0 || cmd_ch.valid || span_expect.size() != 0)
                   && quiet < DRAIN_LIMIT);
        if (span_expect.size() != 0) begin
            report_mismatch($sformatf("%0d expected spans never arrived",
                                      span_expect.size()));
            span_expect.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Clock and known input levels from time zero
    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.cmd           = SHAPE_DISC;
        cmd_ch.centre_x      = '0;
        cmd_ch.centre_y      = '0;
        cmd_ch.outer_radius  = '0;
        cmd_ch.inner_radius  = '0;
        cmd_ch.fill_color    = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_BAND_LEFT;
        cfg_ch.data          = '0;
        span_ch.ready        = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Command driver: takes the next shape on accept, idles at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) predict_spans(cmd_on_bus);
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    cmd_on_bus           = pending_cmds.pop_front();
                    cmd_ch.valid        <= 1'b1;
                    cmd_ch.cmd          <= cmd_on_bus.kind;
                    cmd_ch.centre_x     <= cmd_on_bus.cx;
                    cmd_ch.centre_y     <= cmd_on_bus.cy;
                    cmd_ch.outer_radius <= cmd_on_bus.ro;
                    cmd_ch.inner_radius <= cmd_on_bus.ri;
                    cmd_ch.fill_color   <= cmd_on_bus.color;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Span monitor: compare each transaction with the oldest expected span
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            span_ch.ready <= 1'b0;
        end else begin
            if (span_ch.valid && span_ch.ready) begin
                span_count++;
                if (span_expect.size() == 0) begin
                    report_mismatch($sformatf("span %0d: row %0d start %0d len %0d unexpected",
                                              span_count, span_ch.span_row,
                                              span_ch.span_start, span_ch.span_length));
                end else begin
                    want_span = span_expect.pop_front();
                    if (span_ch.span_row !== want_span.row)
                        report_mismatch($sformatf("span %0d row: got %0d, expected %0d",
                                                  span_count, span_ch.span_row, want_span.row));
                    if (span_ch.span_start !== want_span.start)
                        report_mismatch($sformatf("span %0d start: got %0d, expected %0d",
                                                  span_count, span_ch.span_start,
                                                  want_span.start));
                    if (span_ch.span_length !== want_span.length)
                        report_mismatch($sformatf("span %0d length: got %0d, expected %0d",
                                                  span_count, span_ch.span_length,
                                                  want_span.length));
                    if (span_ch.span_color !== want_span.color)
                        report_mismatch($sformatf("span %0d color: got %h, expected %h",
                                                  span_count, span_ch.span_color,
                                                  want_span.color));
                    if (span_ch.last_span !== want_span.last)
                        report_mismatch($sformatf("span %0d last: got %b, expected %b",
                                                  span_count, span_ch.last_span,
                                                  want_span.last));
                end
            end
            span_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Stimulus phases
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed shapes against the reset band (320 x 16 at the origin)
        add_cmd(SHAPE_DISC, 10, 5, 0, 0, 16'h0000);          // single pixel
        add_cmd(SHAPE_DISC, 160, 8, 127, 0, 16'hFFFF);       // largest disc
        add_cmd(SHAPE_RING, 160, 8, 127, 0, 16'h1234);       // zero hole
        add_cmd(SHAPE_RING, 100, 8, 20, 10, 16'hA5A5);
        add_cmd(SHAPE_RING, 50, 8, 5, 9, 16'h5A5A);          // hole wider than shape
        add_cmd(SHAPE_RING, 200, 7, 10, 7, 16'h0F0F);        // hole edge rows in band
        add_cmd(SHAPE_RING, 30, 3, 6, 0, 16'hF0F0);          // open centre pixel only
        add_cmd(SHAPE_DISC, 100, 200, 10, 0, 16'h0001);      // misses the band
        add_cmd(SHAPE_DISC, 0, 0, 30, 0, 16'h8000);          // clipped top-left
        add_cmd(SHAPE_DISC, 319, 15, 5, 0, 16'h7FFF);        // bottom-right corner
        add_cmd(SHAPE_DISC, -32768, -32768, 127, 127, 16'h00FF);
        add_cmd(SHAPE_RING, 32767, 32767, 127, 127, 16'hFF00);
        add_cmd(SHAPE_DISC, 40, -127, 127, 0, 16'h3C3C);     // grazes row 0
        add_cmd(SHAPE_RING, 160, 8, 127, 127, 16'hC3C3);     // hole covers band
        add_cmd(SHAPE_RING, 20, 4, 0, 0, 16'h1111);          // degenerate ring
        add_cmd(SHAPE_DISC, 5, 15, 1, 127, 16'h2222);        // inner radius ignored
        add_cmd(SHAPE_RING, -1, 8, 3, 127, 16'h3333);
        add_cmd(SHAPE_DISC, 330, 8, 12, 0, 16'h4444);        // right overhang
        add_cmd(SHAPE_RING, 160, 0, 127, 126, 16'h5555);     // thin ring
        add_random(12);
        wait_idle();

        // Shifted band, open clip; sender pauses midway until all spans are back
        write_all_regs(-40, 96, 200, 16, -CLIP_BOUND, -CLIP_BOUND, CLIP_BOUND, CLIP_BOUND);
        add_random(35);
        wait_idle();
        add_random(35);
        wait_idle();

        // Oversized band trimmed to panel limits, left clip edge inside the band
        src_idle_pct  = 47;
        sink_idle_pct = 11;
        write_all_regs(1000, -8, 511, 31, 1010, -CLIP_BOUND, CLIP_BOUND, CLIP_BOUND);
        add_random(60);
        wait_idle();

        // Empty band, coordinate extremes and inverted clip: nothing drawn
        write_all_regs(-32768, 32767, 0, 0, CLIP_BOUND, CLIP_BOUND, -CLIP_BOUND, -CLIP_BOUND);
        add_random(12);
        wait_idle();

        // Clip rectangle inside the band on all four sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_all_regs(-16400, -16390, 320, 16, -CLIP_BOUND, -CLIP_BOUND, -16100, -16378);
        add_random(50);
        wait_idle();

        // Single-row band
        write_all_regs(0, 0, 320, 1, -CLIP_BOUND, -CLIP_BOUND, CLIP_BOUND, CLIP_BOUND);
        add_random(36);
        wait_idle();

        if (n_errors == 0) begin
            $display("disc_ring_span_rasterizer verification clean");
        end else begin
            $display("disc_ring_span_rasterizer verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #RUN_LIMIT;
        $display("disc_ring_span_rasterizer verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/drsr_pkg.sv
rtl/drsr_ifs.sv
rtl/drsr_front.sv
rtl/drsr_fifo.sv
rtl/drsr_root.sv
rtl/drsr_back.sv
rtl/disc_ring_span_rasterizer.sv
dv/tb_disc_ring_span_rasterizer.sv
